[rtl/egcd_pkg.sv]
// Package for the extended GCD core: field widths, controller states and
// the command/status structs between controller and datapath.
// No dependencies.
package egcd_pkg;

    localparam int OPND_W       = 31;
    localparam int OUT_COEF_W   = 32;
    localparam int COEF_W_DFLT  = 32;
    localparam int STEP_CNT_W   = $clog2(OPND_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_UPD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic start_div;
        logic step;
        logic update;
        logic capture;
    } t_dp_cmd;

    typedef struct packed {
        logic den_zero;
        logic step_last;
    } t_dp_status;

endpackage

[rtl/egcd_ctrl.sv]
// Controller for the extended GCD core: sequences load, bit-serial divide,
// coefficient update and result capture. Depends on egcd_pkg.
module egcd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  egcd_pkg::t_dp_status  i_status,
    output egcd_pkg::t_dp_cmd     o_cmd
);

    egcd_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= egcd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            egcd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = egcd_pkg::S_CHECK;
                end
            end
            egcd_pkg::S_CHECK: begin
                if (i_status.den_zero) begin
                    n_state = egcd_pkg::S_DONE;
                end else begin
                    o_cmd.start_div = 1'b1;
                    n_state         = egcd_pkg::S_DIV;
                end
            end
            egcd_pkg::S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.step_last) begin
                    n_state = egcd_pkg::S_UPD;
                end
            end
            egcd_pkg::S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = egcd_pkg::S_CHECK;
            end
            egcd_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = egcd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = egcd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/egcd_dpath.sv]
// Datapath for the extended GCD core: remainder pair, restoring divider
// with shift-add quotient products, Bezout pairs, result registers.
// Depends on egcd_pkg.
module egcd_dpath #(
    parameter int WIDTH = egcd_pkg::COEF_W_DFLT
) (
    input  logic                                  i_clk,
    input  egcd_pkg::t_dp_cmd                     i_cmd,
    input  logic [egcd_pkg::OPND_W-1:0]           i_operand_a,
    input  logic [egcd_pkg::OPND_W-1:0]           i_operand_b,
    output egcd_pkg::t_dp_status                  o_status,
    output logic [egcd_pkg::OPND_W-1:0]           o_gcd_value,
    output logic signed [egcd_pkg::OUT_COEF_W-1:0] o_coeff_x,
    output logic signed [egcd_pkg::OUT_COEF_W-1:0] o_coeff_y
);

    localparam int OW = egcd_pkg::OPND_W;
    localparam int CW = egcd_pkg::OUT_COEF_W;
    localparam int NW = egcd_pkg::STEP_CNT_W;
    localparam logic [NW-1:0] LAST_STEP = NW'(OW - 1);

    logic [OW-1:0]    r_num, r_den, r_rem, r_dvd;
    logic [NW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_cx, r_cy, r_nx, r_ny, r_accx, r_accy;
    logic [OW-1:0]    r_gcd;
    logic [CW-1:0]    r_ox, r_oy;

    logic [OW:0]      trial;
    logic [OW-1:0]    diff;
    logic             ge;
    logic [CW-1:0]    ext_x, ext_y;

    assign trial = {r_rem, r_dvd[OW-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial[OW-1:0] - r_den;

    generate
        if (WIDTH >= CW) begin : g_trunc
            assign ext_x = r_cx[CW-1:0];
            assign ext_y = r_cy[CW-1:0];
        end else begin : g_sext
            assign ext_x = {{(CW-WIDTH){r_cx[WIDTH-1]}}, r_cx};
            assign ext_y = {{(CW-WIDTH){r_cy[WIDTH-1]}}, r_cy};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num <= i_operand_a;
            r_den <= i_operand_b;
            r_cx  <= WIDTH'(1);
            r_cy  <= '0;
            r_nx  <= '0;
            r_ny  <= WIDTH'(1);
        end
        if (i_cmd.start_div) begin
            r_rem  <= '0;
            r_dvd  <= r_num;
            r_cnt  <= '0;
            r_accx <= '0;
            r_accy <= '0;
        end
        if (i_cmd.step) begin
            r_rem  <= ge ? diff : trial[OW-1:0];
            r_dvd  <= {r_dvd[OW-2:0], 1'b0};
            r_cnt  <= r_cnt + NW'(1);
            r_accx <= {r_accx[WIDTH-2:0], 1'b0} + (ge ? r_nx : '0);
            r_accy <= {r_accy[WIDTH-2:0], 1'b0} + (ge ? r_ny : '0);
        end
        if (i_cmd.update) begin
            r_num <= r_den;
            r_den <= r_rem;
            r_cx  <= r_nx;
            r_cy  <= r_ny;
            r_nx  <= r_cx - r_accx;
            r_ny  <= r_cy - r_accy;
        end
        if (i_cmd.capture) begin
            r_gcd <= r_num;
            r_ox  <= ext_x;
            r_oy  <= ext_y;
        end
    end

    assign o_status.den_zero  = (r_den == '0);
    assign o_status.step_last = (r_cnt == LAST_STEP);
    assign o_gcd_value        = r_gcd;
    assign o_coeff_x          = r_ox;
    assign o_coeff_y          = r_oy;

endmodule

[rtl/extended_gcd_core.sv]
// Extended GCD core. An input transaction runs k Euclid steps before its result
// is valid, k at most 45 for 31-bit operands. Each step is a bit-serial
// restoring divide between a check state and an update state. A new input is
// taken only in idle, after the previous result has been captured; it is taken
// while a result waits, and the next result holds until that one is taken.
// Synchronous active-low reset clears controller state and result valid.
module extended_gcd_core #(
    parameter int WIDTH = egcd_pkg::COEF_W_DFLT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [egcd_pkg::OPND_W-1:0]            i_operand_a,
    input  logic [egcd_pkg::OPND_W-1:0]            i_operand_b,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [egcd_pkg::OPND_W-1:0]            o_gcd_value,
    output logic signed [egcd_pkg::OUT_COEF_W-1:0] o_coeff_x,
    output logic signed [egcd_pkg::OUT_COEF_W-1:0] o_coeff_y
);

    egcd_pkg::t_dp_cmd    cmd;
    egcd_pkg::t_dp_status status;

    egcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    egcd_dpath #(
        .WIDTH (WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_status    (status),
        .o_gcd_value (o_gcd_value),
        .o_coeff_x   (o_coeff_x),
        .o_coeff_y   (o_coeff_y)
    );

endmodule

[test/tb_extended_gcd_core.sv]
// Testbench for extended_gcd_core: walks a directed table, then random operand pairs.
// Each result is scored against a typed row want or else a local Bezout predictor at the
// core's coefficient width. Depends on egcd_pkg and extended_gcd_core from rtl/.
`timescale 1ns / 1ps

module tb_extended_gcd_core;

    localparam int OPND_W        = egcd_pkg::OPND_W;
    localparam int OUT_COEF_W    = egcd_pkg::OUT_COEF_W;
    localparam int COEF_W        = egcd_pkg::COEF_W_DFLT;
    localparam int NUM_RANDOM    = 1680;
    localparam int CYCLE_LIMIT   = 12_000_000;
    localparam int DRAIN_CYCLES  = 1600;
    localparam int STALL_CYCLES  = 4000;
    localparam int STALL_AT      = 400;
    localparam int CALM_FIRST    = 600;
    localparam int CALM_LAST     = 800;
    localparam int MAX_REPORTS   = 10;
    localparam int NUM_DIRECTED  = 18;

    localparam logic [OPND_W-1:0] OPND_MAX = {OPND_W{1'b1}};
    localparam logic [OPND_W-1:0] FIB_45   = 31'd1134903170;
    localparam logic [OPND_W-1:0] FIB_46   = 31'd1836311903;

    typedef struct packed {
        logic [OPND_W-1:0]     gcd_value;
        logic [OUT_COEF_W-1:0] coeff_x;
        logic [OUT_COEF_W-1:0] coeff_y;
    } t_egcd_result;

    typedef struct packed {
        logic [OPND_W-1:0] operand_a;
        logic [OPND_W-1:0] operand_b;
        logic              typed;
        t_egcd_result      want;
    } t_directed_row;

    localparam t_egcd_result NO_WANT = '{31'd0, 32'd0, 32'd0};

    localparam t_directed_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{31'd0,         31'd0,         1'b1, '{31'd0,         32'd1, 32'd0}},
        '{OPND_MAX,      31'd0,         1'b1, '{OPND_MAX,      32'd1, 32'd0}},
        '{31'd0,         OPND_MAX,      1'b1, '{OPND_MAX,      32'd0, 32'd1}},
        '{31'd1,         31'd0,         1'b1, '{31'd1,         32'd1, 32'd0}},
        '{31'd0,         31'd1,         1'b1, '{31'd1,         32'd0, 32'd1}},
        '{31'h5555_5555, 31'd0,         1'b1, '{31'h5555_5555, 32'd1, 32'd0}},
        '{OPND_MAX,      OPND_MAX,      1'b0, NO_WANT},
        '{31'd1,         31'd1,         1'b0, NO_WANT},
        '{OPND_MAX,      OPND_MAX - 1,  1'b0, NO_WANT},
        '{31'd1,         OPND_MAX,      1'b0, NO_WANT},
        '{31'd3,         31'd7,         1'b0, NO_WANT},
        '{FIB_46,        FIB_45,        1'b0, NO_WANT},
        '{FIB_45,        FIB_46,        1'b0, NO_WANT},
        '{31'h4000_0000, 31'h3FFF_FFFF, 1'b0, NO_WANT},
        '{31'h5555_5555, 31'h2AAA_AAAA, 1'b0, NO_WANT},
        '{31'd240,       31'd46,        1'b0, NO_WANT},
        '{31'h4000_0000, 31'h0010_0000, 1'b0, NO_WANT},
        '{31'd1000000007, 31'd998244353, 1'b0, NO_WANT}
    };

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic [OPND_W-1:0]            i_operand_a = '0;
    logic [OPND_W-1:0]            i_operand_b = '0;
    logic                         i_out_ready = 1'b0;
    logic                         o_in_ready;
    logic                         o_out_valid;
    logic [OPND_W-1:0]            o_gcd_value;
    logic signed [OUT_COEF_W-1:0] o_coeff_x;
    logic signed [OUT_COEF_W-1:0] o_coeff_y;

    t_egcd_result pending_results [$];
    t_egcd_result scored_want;
    int           items_sent      = 0;
    int           results_checked = 0;
    int           mismatch_count  = 0;
    int           unexpected_count = 0;
    int           report_count    = 0;
    int           deepest_chain   = 0;
    int           cycle_count     = 0;
    bit           calm_phase      = 1'b0;
    bit           stall_done      = 1'b0;

    extended_gcd_core #(
        .WIDTH(COEF_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_gcd_value (o_gcd_value),
        .o_coeff_x   (o_coeff_x),
        .o_coeff_y   (o_coeff_y)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    function automatic logic [OUT_COEF_W-1:0] coef_to_port(input logic [63:0] value,
                                                           input logic [63:0] mask);
        logic [63:0] ext;
        ext = value & mask;
        if (ext[COEF_W-1]) begin
            ext = ext | ~mask;
        end
        return ext[OUT_COEF_W-1:0];
    endfunction

    function automatic t_egcd_result bezout_predict(input logic [OPND_W-1:0] a,
                                                    input logic [OPND_W-1:0] b,
                                                    output int chain);
        logic [63:0]  mask;
        logic [63:0]  num;
        logic [63:0]  den;
        logic [63:0]  cx;
        logic [63:0]  cy;
        logic [63:0]  nx;
        logic [63:0]  ny;
        logic [63:0]  quo;
        logic [63:0]  rem;
        logic [63:0]  tx;
        logic [63:0]  ty;
        t_egcd_result res;
        mask  = {64{1'b1}} >> (64 - COEF_W);
        num   = {33'd0, a};
        den   = {33'd0, b};
        cx    = 64'd1;
        cy    = 64'd0;
        nx    = 64'd0;
        ny    = 64'd1;
        chain = 0;
        while (den != 64'd0) begin
            quo = num / den;
            rem = num % den;
            tx  = (cx - quo * nx) & mask;
            ty  = (cy - quo * ny) & mask;
            num = den;
            den = rem;
            cx  = nx;
            cy  = ny;
            nx  = tx;
            ny  = ty;
            chain++;
        end
        res.gcd_value = num[OPND_W-1:0];
        res.coeff_x   = coef_to_port(cx, mask);
        res.coeff_y   = coef_to_port(cy, mask);
        return res;
    endfunction

    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(21, 150);
    endfunction

    function automatic logic [OPND_W-1:0] rand_operand();
        logic [31:0] raw;
        raw = $urandom;
        return raw[OPND_W-1:0];
    endfunction

    // hold valid across back-to-back transactions; drop it only for a gap
    task automatic drive_operands(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b,
                                  input t_egcd_result want);
        int gap;
        gap = calm_phase ? 0 : pick_idle();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operand_a <= a;
        i_operand_b <= b;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        pending_results.push_back(want);
        items_sent++;
        calm_phase = (items_sent >= CALM_FIRST) && (items_sent < CALM_LAST);
    endtask

    task automatic pick_random_pair(output logic [OPND_W-1:0] a, output logic [OPND_W-1:0] b);
        int          roll;
        int          steps;
        int          k;
        logic [31:0] factor;
        logic [31:0] fa;
        logic [31:0] fb;
        logic [31:0] fc;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            a = rand_operand();
            b = rand_operand();
        end else if (roll < 60) begin
            a = OPND_W'($urandom_range(0, 255));
            b = OPND_W'($urandom_range(0, 255));
        end else if (roll < 75) begin
            a = OPND_W'($urandom_range(0, 65535));
            b = OPND_W'($urandom_range(0, 65535));
        end else if (roll < 85) begin
            factor = $urandom_range(1, 1000);
            fa     = factor * $urandom_range(0, 2000000);
            fb     = factor * $urandom_range(0, 2000000);
            a      = fa[OPND_W-1:0];
            b      = fb[OPND_W-1:0];
        end else if (roll < 92) begin
            a = rand_operand();
            case ($urandom_range(0, 2))
                0: b = '0;
                1: begin
                    b = a;
                    a = '0;
                end
                default: b = a;
            endcase
        end else begin
            k  = $urandom_range(1, 45);
            fa = 32'd1;
            fb = 32'd1;
            for (steps = 0; steps < k; steps++) begin
                fc = fa + fb;
                fa = fb;
                fb = fc;
            end
            if ($urandom_range(0, 1) == 0) begin
                a = fb[OPND_W-1:0];
                b = fa[OPND_W-1:0];
            end else begin
                a = fa[OPND_W-1:0];
                b = fb[OPND_W-1:0];
            end
        end
    endtask

    initial begin
        t_egcd_result      want;
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
        int                chain;
        int                row;
        int                n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (row = 0; row < NUM_DIRECTED; row++) begin
            want = bezout_predict(DIRECTED_ROWS[row].operand_a, DIRECTED_ROWS[row].operand_b,
                                  chain);
            if (chain > deepest_chain) begin
                deepest_chain = chain;
            end
            if (DIRECTED_ROWS[row].typed) begin
                want = DIRECTED_ROWS[row].want;
            end
            drive_operands(DIRECTED_ROWS[row].operand_a, DIRECTED_ROWS[row].operand_b, want);
        end
        for (n = 0; n < NUM_RANDOM; n++) begin
            pick_random_pair(a, b);
            want = bezout_predict(a, b, chain);
            if (chain > deepest_chain) begin
                deepest_chain = chain;
            end
            drive_operands(a, b, want);
        end
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d transactions (%0d directed), scored %0d results",
                 items_sent, NUM_DIRECTED, results_checked);
        $display("longest Euclid chain %0d steps, %0d mismatches, %0d unexpected results",
                 deepest_chain, mismatch_count, unexpected_count);
        if (mismatch_count == 0 && unexpected_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        int run;
        int gap;
        int hold_count;
        @(posedge i_clk);
        forever begin
            if (!stall_done && results_checked >= STALL_AT) begin
                stall_done = 1'b1;
                i_out_ready <= 1'b0;
                for (hold_count = 0; hold_count < STALL_CYCLES; hold_count++) begin
                    @(posedge i_clk);
                end
            end else if (calm_phase) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                run = $urandom_range(1, 20);
                gap = pick_idle();
                i_out_ready <= 1'b1;
                repeat (run) @(posedge i_clk);
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                unexpected_count++;
                if (report_count < MAX_REPORTS) begin
                    $display("unexpected result: gcd %0d x %0d y %0d", o_gcd_value,
                             o_coeff_x, o_coeff_y);
                end
                report_count++;
            end else begin
                scored_want = pending_results.pop_front();
                if (o_gcd_value !== scored_want.gcd_value ||
                    o_coeff_x !== scored_want.coeff_x ||
                    o_coeff_y !== scored_want.coeff_y) begin
                    mismatch_count++;
                    if (report_count < MAX_REPORTS) begin
                        $display({"mismatch at result %0d: want gcd %0d x %0d y %0d, ",
                                  "got gcd %0d x %0d y %0d"},
                                 results_checked, scored_want.gcd_value,
                                 $signed(scored_want.coeff_x), $signed(scored_want.coeff_y),
                                 o_gcd_value, o_coeff_x, o_coeff_y);
                    end
                    report_count++;
                end
            end
            results_checked++;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
    end

endmodule
